[rtl/compacting_first_fit_allocator_macros.svh]
// Assertion macros used by the allocator.
`ifndef COMPACTING_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define COMPACTING_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ffa_pkg.sv]
package ffa_pkg;

	// Pool geometry.
	localparam int MEM_WORDS  = 128;
	localparam int AW         = $clog2(MEM_WORDS);
	localparam int WORD_BYTES = 4;
	localparam int HDR_WORDS  = 3;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_RELOC = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOM  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [9:0]  byte_count;
		logic [31:0] owner_tag;
		logic [6:0]  free_offset;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [6:0]  word_offset;
		logic [31:0] tag_out;
		logic        last;
	} result_t;

	// One access slot of the pool memory per cycle.
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [31:0]   wdata;
		logic [AW-1:0] raddr;
	} ram_req_t;

	// Words taken by an allocation whose header holds this size, saturated at 256,
	// which is already past the end of any pool.
	function automatic logic [8:0] words_of(input logic [31:0] w);
		logic [8:0] n;
		if (|w[31:9]) begin
			n = 9'h100;
		end else begin
			n = {2'b00, w[8:2]} + {8'd0, |w[1:0]} + 9'(HDR_WORDS);
		end
		return n;
	endfunction

endpackage

[rtl/ffa_ram.sv]
module ffa_ram (
	input  logic              clk,
	input  ffa_pkg::ram_req_t req,
	output logic [31:0]       rdata
);
	import ffa_pkg::*;

	logic [31:0] mem [MEM_WORDS];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

[rtl/compacting_first_fit_allocator.sv]
// First-fit allocator over a pool of 128 words of 32 bits held in one single-port-write,
// registered-read memory. A word is accepted when start is high and busy is low; each
// result appears for one cycle with strobe high and must be taken then, as there is no
// back-pressure. After reset the block clears all 128 words of the pool with busy high
// (configuration writes are still taken). Timing is set by the memory port: each scan step
// reads a word and then evaluates it, and an allocate steps through the header and free
// words in each scan pass. A compaction walks the pool the same way, copies each moved word
// with a read and a write, clears each vacated word, then fixes the header and reads the
// tag of each moved allocation. A free reads the size word and clears each word of the
// allocation before it gives its result.
`include "compacting_first_fit_allocator_macros.svh"

module compacting_first_fit_allocator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ffa_pkg::cmd_t    command,
	output logic             strobe,
	output ffa_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data
);
	import ffa_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_SC_RD, S_SC_EV, S_HDR0, S_HDR1, S_HDR2,
		S_CP_RD, S_CP_EV, S_MV_RD, S_MV_WR, S_ZERO, S_FIX, S_TAG_RD, S_TAG_EV,
		S_FR_RD, S_FR_EV, S_FR_ZERO
	} state_t;

	state_t         state_q;
	logic [7:0]     pool_words_q;
	logic [AW-1:0]  clr_q;
	logic [9:0]     i_q, hole_q, z_q, zend_q;
	logic [7:0]     run_q, cnt_q, k_q;
	logic [AW-1:0]  s_q;
	logic           in_run_q, pass_q;
	logic [8:0]     need_q, aw_q;
	logic [9:0]     bytes_q;
	logic [31:0]    tag_q;
	logic [6:0]     foff_q;
	logic           strobe_q;
	result_t        res_q;

	ram_req_t       req;
	logic [31:0]    rdata;

	logic [7:0]     size;
	logic [9:0]     size_x, src_idx, dst_idx, hole_p1, hole_p2, hole_p3;
	logic [8:0]     w_words;
	logic [9:0]     need_in;
	logic [7:0]     s_p3;

	ffa_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	// Effective pool size and address arithmetic.
	assign size    = (pool_words_q > 8'(MEM_WORDS)) ? 8'(MEM_WORDS) : pool_words_q;
	assign size_x  = {2'b00, size};
	assign src_idx = i_q + {2'b00, k_q};
	assign dst_idx = hole_q + {2'b00, k_q};
	assign hole_p1 = hole_q + 10'd1;
	assign hole_p2 = hole_q + 10'd2;
	assign hole_p3 = hole_q + 10'(HDR_WORDS);
	assign s_p3    = {1'b0, s_q} + 8'(HDR_WORDS);
	assign w_words = words_of(rdata);
	assign need_in = 10'(({2'b00, command.byte_count} + 12'(WORD_BYTES - 1)) >> 2)
		+ 10'(HDR_WORDS);

	// Memory access for each state.
	always_comb begin
		req = '0;
		unique case (state_q)
			S_CLR: begin
				req.we    = 1'b1;
				req.waddr = clr_q;
			end
			S_SC_RD, S_CP_RD: req.raddr = i_q[AW-1:0];
			S_HDR0: begin
				req.we    = 1'b1;
				req.waddr = s_q;
				req.wdata = {22'd0, bytes_q};
			end
			S_HDR1: begin
				req.we    = 1'b1;
				req.waddr = s_q + AW'(1);
				req.wdata = {24'd0, s_p3};
			end
			S_HDR2: begin
				req.we    = 1'b1;
				req.waddr = s_q + AW'(2);
				req.wdata = tag_q;
			end
			S_MV_RD: req.raddr = src_idx[AW-1:0];
			S_MV_WR: begin
				req.we    = 1'b1;
				req.waddr = dst_idx[AW-1:0];
				req.wdata = rdata;
			end
			S_ZERO, S_FR_ZERO: begin
				req.we    = 1'b1;
				req.waddr = z_q[AW-1:0];
			end
			S_FIX: begin
				req.we    = (hole_p1 < size_x);
				req.waddr = hole_p1[AW-1:0];
				req.wdata = {22'd0, hole_p3};
			end
			S_TAG_RD: req.raddr = hole_p2[AW-1:0];
			S_FR_RD: req.raddr = foff_q;
			default: req = '0;
		endcase
	end

	// Command sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			pool_words_q <= 8'd128;
			clr_q        <= '0;
			strobe_q     <= 1'b0;
			in_run_q     <= 1'b0;
			pass_q       <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				pool_words_q <= cfg_data;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MEM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						bytes_q  <= command.byte_count;
						tag_q    <= command.owner_tag;
						foff_q   <= command.free_offset;
						need_q   <= need_in[8:0];
						i_q      <= '0;
						in_run_q <= 1'b0;
						pass_q   <= 1'b0;
						if (command.cmd == CMD_FREE) begin
							if ({1'b0, command.free_offset} < size) begin
								state_q <= S_FR_RD;
							end else begin
								strobe_q <= 1'b1;
								res_q    <= '{KIND_FREE, ST_OK, command.free_offset, 32'd0, 1'b1};
							end
						end else if (command.byte_count == '0) begin
							strobe_q <= 1'b1;
							res_q    <= '{KIND_ALLOC, ST_ZERO, 7'd0, command.owner_tag, 1'b1};
						end else begin
							state_q <= S_SC_RD;
						end
					end
				end
				// First-fit scan: read a word, then evaluate it.
				S_SC_RD: begin
					if (i_q >= size_x) begin
						if (!pass_q) begin
							pass_q  <= 1'b1;
							i_q     <= '0;
							hole_q  <= '0;
							state_q <= S_CP_RD;
						end else begin
							strobe_q <= 1'b1;
							res_q    <= '{KIND_ALLOC, ST_OOM, 7'd0, tag_q, 1'b1};
							state_q  <= S_IDLE;
						end
					end else begin
						state_q <= S_SC_EV;
					end
				end
				S_SC_EV: begin
					state_q <= S_SC_RD;
					if (!in_run_q) begin
						if (rdata == '0) begin
							s_q      <= i_q[AW-1:0];
							run_q    <= 8'd1;
							in_run_q <= 1'b1;
							i_q      <= i_q + 10'd1;
						end else begin
							i_q <= i_q + {1'b0, w_words};
						end
					end else if (rdata == '0) begin
						if ({2'b00, run_q} + 10'd1 >= {1'b0, need_q}) begin
							state_q <= S_HDR0;
						end else begin
							run_q <= run_q + 8'd1;
							i_q   <= i_q + 10'd1;
						end
					end else begin
						// Run broken: look at this word again as a header.
						in_run_q <= 1'b0;
					end
				end
				S_HDR0: state_q <= S_HDR1;
				S_HDR1: state_q <= S_HDR2;
				S_HDR2: begin
					strobe_q <= 1'b1;
					res_q    <= '{KIND_ALLOC, ST_OK, 7'(s_q), tag_q, 1'b1};
					state_q  <= S_IDLE;
				end
				// Compaction walk.
				S_CP_RD: begin
					if (i_q >= size_x) begin
						i_q      <= '0;
						in_run_q <= 1'b0;
						state_q  <= S_SC_RD;
					end else begin
						state_q <= S_CP_EV;
					end
				end
				S_CP_EV: begin
					state_q <= S_CP_RD;
					if (rdata == '0) begin
						i_q <= i_q + 10'd1;
					end else if (hole_q == i_q) begin
						i_q    <= i_q + {1'b0, w_words};
						hole_q <= i_q + {1'b0, w_words};
					end else if (i_q - hole_q >= {1'b0, need_q}) begin
						i_q      <= '0;
						in_run_q <= 1'b0;
						state_q  <= S_SC_RD;
					end else begin
						aw_q    <= w_words;
						k_q     <= '0;
						cnt_q   <= ({1'b0, w_words} > size_x - i_q) ? 8'(size_x - i_q)
							: w_words[7:0];
						state_q <= S_MV_RD;
					end
				end
				S_MV_RD: state_q <= S_MV_WR;
				S_MV_WR: begin
					k_q <= k_q + 8'd1;
					if (k_q + 8'd1 == cnt_q) begin
						z_q     <= hole_q + {2'b00, cnt_q};
						zend_q  <= i_q + {2'b00, cnt_q};
						state_q <= S_ZERO;
					end else begin
						state_q <= S_MV_RD;
					end
				end
				S_ZERO: begin
					z_q <= z_q + 10'd1;
					if (z_q + 10'd1 == zend_q) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: state_q <= S_TAG_RD;
				S_TAG_RD: state_q <= S_TAG_EV;
				S_TAG_EV: begin
					strobe_q <= 1'b1;
					res_q    <= '{KIND_RELOC, ST_OK, hole_q[6:0],
						(hole_p2 < size_x) ? rdata : 32'd0, 1'b0};
					hole_q   <= hole_q + {1'b0, aw_q};
					i_q      <= i_q + {1'b0, aw_q};
					state_q  <= S_CP_RD;
				end
				// Free: read the size word, then clear the allocation.
				S_FR_RD: state_q <= S_FR_EV;
				S_FR_EV: begin
					z_q     <= {3'd0, foff_q};
					zend_q  <= ({3'd0, foff_q} + {1'b0, w_words} > size_x) ? size_x
						: {3'd0, foff_q} + {1'b0, w_words};
					state_q <= S_FR_ZERO;
				end
				S_FR_ZERO: begin
					z_q <= z_q + 10'd1;
					if (z_q + 10'd1 == zend_q) begin
						strobe_q <= 1'b1;
						res_q    <= '{KIND_FREE, ST_OK, foff_q, 32'd0, 1'b1};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

	`FFA_ASSERT_NOW(a_reloc_mid_cmd, clk, arst_n, strobe && !result.last, busy, "relocation word outside a command")
	`FFA_ASSERT_NOW(a_reloc_fields, clk, arst_n, strobe && result.kind == KIND_RELOC, result.status == ST_OK && !result.last, "bad relocation word")
	`FFA_ASSERT_NOW(a_no_result_clr, clk, arst_n, state_q == S_CLR, !strobe, "result during clearing pass")
	`FFA_ASSERT_NEXT(a_done_idle, clk, arst_n, strobe_q == 1'b0 && busy && (state_q == S_HDR2 || state_q == S_FR_ZERO) && (state_q == S_HDR2 || z_q + 10'd1 == zend_q), strobe && result.last && !busy, "final word not followed by idle")

endmodule

[test/tb_compacting_first_fit_allocator.sv]
module tb_compacting_first_fit_allocator;
	import ffa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t command = '0;
	logic strobe;
	result_t result;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'd0;

	compacting_first_fit_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow of the pool and of the size register.
	logic [31:0] pool_mirror [MEM_WORDS];
	logic [7:0] pool_words_sh;
	cmd_t pending_words[$];
	result_t awaited_results[$];
	int unsigned cycle_count = 0;
	int unsigned n_errors = 0;
	int unsigned n_results = 0;
	int unsigned n_relocs = 0;
	int unsigned n_oom = 0;
	int unsigned n_sent = 0;
	bit calm = 1'b0;

	function automatic int unsigned eff_size();
		return (pool_words_sh < MEM_WORDS) ? pool_words_sh : MEM_WORDS;
	endfunction

	function automatic longint unsigned span_of(logic [31:0] w);
		return (longint'(w) + WORD_BYTES - 1) / WORD_BYTES + HDR_WORDS;
	endfunction

	function automatic result_t mk_res(logic [1:0] k, logic [1:0] s, logic [6:0] o,
			logic [31:0] t, logic l);
		result_t r;
		r.kind = k; r.status = s; r.word_offset = o; r.tag_out = t; r.last = l;
		return r;
	endfunction

	// First-fit search over the shadow pool.
	function automatic bit search_gap(longint unsigned need, output longint unsigned at);
		longint unsigned i, run, s, sz;
		bit in_run;
		logic [31:0] w;
		sz = eff_size(); i = 0; run = 0; s = 0; in_run = 0; at = 0;
		while (i < sz) begin
			w = pool_mirror[i];
			if (!in_run) begin
				if (w == 0) begin
					s = i; run = 1; in_run = 1; i++;
				end else begin
					i += span_of(w);
				end
			end else if (w == 0) begin
				run++;
				if (run >= need) begin
					at = s;
					return 1;
				end
				i++;
			end else begin
				in_run = 0;
			end
		end
		return 0;
	endfunction

	// Slide allocations down, queueing relocation notices.
	task automatic slide_down(longint unsigned need);
		longint unsigned i, hole, sz, aw, cnt, c0, c1;
		logic [31:0] w, t;
		logic [31:0] tmp [MEM_WORDS];
		sz = eff_size(); i = 0; hole = 0;
		while (i < sz) begin
			w = pool_mirror[i];
			if (w == 0) begin
				i++;
				continue;
			end
			aw = span_of(w);
			if (hole == i) begin
				i += aw; hole = i;
				continue;
			end
			if (i - hole >= need) break;
			cnt = aw;
			if (cnt > sz - i) cnt = sz - i;
			for (longint unsigned j = 0; j < cnt; j++) tmp[j] = pool_mirror[i + j];
			for (longint unsigned j = 0; j < cnt; j++) pool_mirror[hole + j] = tmp[j];
			c0 = hole + cnt; c1 = i + cnt;
			if (c1 > sz) c1 = sz;
			for (longint unsigned j = c0; j < c1; j++) pool_mirror[j] = 0;
			if (hole + 1 < sz) pool_mirror[hole + 1] = 32'(hole + HDR_WORDS);
			t = (hole + 2 < sz) ? pool_mirror[hole + 2] : 32'd0;
			awaited_results.push_back(mk_res(KIND_RELOC, ST_OK, 7'(hole), t, 1'b0));
			hole += aw; i += aw;
		end
	endtask

	// Work out the results of one accepted word.
	task automatic predict_word(cmd_t c);
		longint unsigned need, at, n, sz;
		bit ok;
		sz = eff_size();
		if (c.cmd == CMD_FREE) begin
			if (c.free_offset < sz) begin
				n = span_of(pool_mirror[c.free_offset]);
				if (n > sz - c.free_offset) n = sz - c.free_offset;
				for (longint unsigned j = 0; j < n; j++) pool_mirror[c.free_offset + j] = 0;
			end
			awaited_results.push_back(mk_res(KIND_FREE, ST_OK, c.free_offset, 32'd0, 1'b1));
		end else if (c.byte_count == 0) begin
			awaited_results.push_back(mk_res(KIND_ALLOC, ST_ZERO, 7'd0, c.owner_tag, 1'b1));
		end else begin
			need = span_of(32'(c.byte_count));
			ok = search_gap(need, at);
			if (!ok) begin
				slide_down(need);
				ok = search_gap(need, at);
			end
			if (ok) begin
				pool_mirror[at] = 32'(c.byte_count);
				pool_mirror[at + 1] = 32'(at + HDR_WORDS);
				pool_mirror[at + 2] = c.owner_tag;
				awaited_results.push_back(mk_res(KIND_ALLOC, ST_OK, 7'(at), c.owner_tag, 1'b1));
			end else begin
				awaited_results.push_back(mk_res(KIND_ALLOC, ST_OOM, 7'd0, c.owner_tag, 1'b1));
			end
		end
	endtask

	// Driver: one word at a time, with random idle bursts.
	int unsigned idle_left = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (start && !busy) begin
				predict_word(command);
				n_sent <= n_sent + 1;
			end
			if (start && busy) begin
				// Hold the word until it is taken.
			end else if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start <= 1'b0;
			end else if (pending_words.size() > 0) begin
				if (!calm && $urandom_range(0, 5) == 0) begin
					idle_left <= $urandom_range(1, 17);
					start <= 1'b0;
				end else begin
					command <= pending_words.pop_front();
					start <= 1'b1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each strobed word with the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && strobe) begin
			n_results <= n_results + 1;
			if (awaited_results.size() == 0) begin
				$error("unexpected result word %h", result);
				n_errors = n_errors + 1;
			end else begin
				e = awaited_results.pop_front();
				if (e.kind == KIND_RELOC) n_relocs <= n_relocs + 1;
				if (e.status == ST_OOM) n_oom <= n_oom + 1;
				if (result.kind !== e.kind) begin
					$error("kind: expected %0d actual %0d", e.kind, result.kind);
					n_errors = n_errors + 1;
				end
				if (result.status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, result.status);
					n_errors = n_errors + 1;
				end
				if (result.word_offset !== e.word_offset) begin
					$error("word_offset: expected %0d actual %0d", e.word_offset,
						result.word_offset);
					n_errors = n_errors + 1;
				end
				if (result.tag_out !== e.tag_out) begin
					$error("tag_out: expected %h actual %h", e.tag_out, result.tag_out);
					n_errors = n_errors + 1;
				end
				if (result.last !== e.last) begin
					$error("last: expected %0d actual %0d", e.last, result.last);
					n_errors = n_errors + 1;
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		if (cycle_count > 2000000) begin
			$display("compacting_first_fit_allocator test failed");
			$finish;
		end
	end

	function automatic cmd_t alloc_word(int unsigned b, logic [31:0] t);
		cmd_t c;
		c = '0; c.cmd = CMD_ALLOC; c.byte_count = 10'(b); c.owner_tag = t;
		c.free_offset = 7'($urandom);
		return c;
	endfunction

	function automatic cmd_t free_word(int unsigned o);
		cmd_t c;
		c = '0; c.cmd = CMD_FREE; c.free_offset = 7'(o);
		c.byte_count = 10'($urandom); c.owner_tag = $urandom;
		return c;
	endfunction

	// Small sizes mostly, so the pool fills, fragments and compacts.
	function automatic cmd_t random_word(int unsigned psz);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return alloc_word($urandom_range(1, 40), $urandom);
		if (r < 55) return alloc_word($urandom_range(0, 1023), $urandom);
		if (r < 57) return alloc_word(0, $urandom);
		if (r < 90) return free_word(($urandom_range(0, 3) == 0) ?
			$urandom_range(0, 127) : 3 * $urandom_range(0, (psz + 2) / 3));
		return free_word($urandom_range(0, 127));
	endfunction

	// Let the block drain, then wait out trailing work.
	task automatic drain();
		while (pending_words.size() > 0 || start || busy || awaited_results.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_pool(logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		pool_words_sh = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0] sizes [6];
		for (int i = 0; i < MEM_WORDS; i++) pool_mirror[i] = 0;
		pool_words_sh = 8'd128;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: extremes of fields, zero size, huge size, odd frees.
		pending_words.push_back(alloc_word(0, 32'hFFFF_FFFF));
		pending_words.push_back(alloc_word(1, 32'h0000_0001));
		pending_words.push_back(alloc_word(4, 32'hAAAA_5555));
		pending_words.push_back(alloc_word(5, 32'h5555_AAAA));
		pending_words.push_back(alloc_word(512, 32'h1234_5678));
		pending_words.push_back(alloc_word(1023, 32'h0));
		pending_words.push_back(alloc_word(100, 32'hDEAD_BEEF));
		pending_words.push_back(free_word(4));
		pending_words.push_back(alloc_word(300, 32'hCAFE_F00D));
		pending_words.push_back(free_word(0));
		pending_words.push_back(free_word(1));
		pending_words.push_back(alloc_word(200, 32'h0BAD_CAFE));
		pending_words.push_back(free_word(127));
		pending_words.push_back(free_word(8));
		pending_words.push_back(alloc_word(20, 32'h7777_7777));
		pending_words.push_back(alloc_word(40, 32'h8888_8888));
		pending_words.push_back(free_word(0));
		pending_words.push_back(alloc_word(60, 32'h9999_9999));
		pending_words.push_back(alloc_word(1, 32'hFFFF_0000));
		drain();
		// Random phases over several pool sizes, extremes included.
		sizes[0] = 8'd128; sizes[1] = 8'd4; sizes[2] = 8'd255;
		sizes[3] = 8'd0; sizes[4] = 8'd37; sizes[5] = 8'd128;
		for (int p = 0; p < 6; p++) begin
			set_pool(sizes[p]);
			if (p == 5) calm = 1'b1;
			for (int i = 0; i < ((p == 1 || p == 3) ? 30 : 95); i++)
				pending_words.push_back(random_word(eff_size()));
			drain();
		end
		$display("Sent %0d command words, checked %0d results (%0d relocations, %0d out of memory).",
			n_sent, n_results, n_relocs, n_oom);
		$display("Pool sizes 0, 4, 37, 128 and 255 were exercised.");
		if (n_errors == 0 && awaited_results.size() == 0) begin
			$display("compacting_first_fit_allocator test passed");
		end else begin
			$display("compacting_first_fit_allocator test failed");
		end
		$finish;
	end
endmodule
